[sv/mhsi_pkg.sv]
// shared types, constants and register map of the magnetometer correction block
`timescale 1ns / 1ps

package mhsi_pkg;

   // sizes
   localparam int unsigned RAW_W       = 24;
   localparam int unsigned GAIN_W      = 18;
   localparam int unsigned ROW_W       = 48;
   localparam int unsigned COEF_W      = 16;
   localparam int unsigned FIELD_W     = 32;
   localparam int unsigned TALLY_W     = 8;
   localparam int unsigned CSR_INDEX_W = 3;

   // parameter defaults
   localparam int unsigned MIN_SAMPLES_DEFAULT = 6;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // commands
   typedef enum logic [1:0] {
      CMD_MEASURE = 2'd0,
      CMD_BEGIN   = 2'd1,
      CMD_SAMPLE  = 2'd2,
      CMD_FINISH  = 2'd3
   } mhsi_cmd_type;

   // register map
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW_X = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW_Y = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW_Z = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CORR_ENABLE  = 3'd4;

   // register reset values, identity matrix in q2.14
   localparam logic [GAIN_W-1:0] SCALE_GAIN_RESET   = 18'd4915;
   localparam logic [ROW_W-1:0]  MATRIX_ROW_X_RESET = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0]  MATRIX_ROW_Y_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0]  MATRIX_ROW_Z_RESET = 48'h4000_0000_0000;

   // saturation limits
   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'h7FFF_FFFF;
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'h8000_0000;

   typedef struct packed {
      mhsi_cmd_type             command;
      logic signed [RAW_W-1:0]  raw_x;
      logic signed [RAW_W-1:0]  raw_y;
      logic signed [RAW_W-1:0]  raw_z;
   } mhsi_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] field_x;
      logic signed [FIELD_W-1:0] field_y;
      logic signed [FIELD_W-1:0] field_z;
      logic                      status;
      logic                      is_calibrated;
   } mhsi_rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [ROW_W-1:0]       value;
   } mhsi_csr_type;

   // classified word between front and back, raw[0] is x
   typedef struct packed {
      mhsi_cmd_type          cmd;
      logic                  needs_scale;
      logic [2:0][RAW_W-1:0] raw;
   } mhsi_item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]     scale_gain;
      logic [2:0][ROW_W-1:0] matrix;
      logic                  correction_enable;
   } mhsi_cfg_type;

endpackage

[sv/mhsi_stream_if.sv]
// valid/ready stream interface carrying one payload word
`timescale 1ns / 1ps

interface mhsi_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/magnetometer_hard_soft_iron_correct.sv]
// Magnetometer hard-iron / soft-iron correction. Each request word carries a
// command and three signed 24-bit axis counts and yields exactly one response
// word. Measure and calibration-sample scale each count by scale_gain (q2.16)
// to microtesla in q24.8, floored and saturated to 32 bits. With
// correction_enable set and a finished calibration, the hard-iron offsets are
// subtracted and the 3x3 soft-iron matrix (q2.14) applied, floored by 2^14 and
// saturated. Begin calibration resets the per-axis min/max and sample tally;
// finish sets the offsets to the floored min/max midpoints when at least
// MIN_SAMPLES samples were taken, else reports status 1; both return zero
// fields. All products go through one shared 33x19 multiplier, one product
// per cycle; begin and finish need no products, an uncorrected measure or
// sample needs three products and a corrected one twelve, the scaling ones first.
// A front register and a QUEUE_DEPTH-word fifo let new words be taken while
// the back end works, and the response register holds a finished word while
// the next one is computed. Configuration is written through the csr port,
// which is always ready; writes to indexes past the register list are dropped.
`timescale 1ns / 1ps

module magnetometer_hard_soft_iron_correct
   import mhsi_pkg::*;
#(
   parameter int unsigned MIN_SAMPLES = MIN_SAMPLES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input logic            clock,
   input logic            reset,
   mhsi_stream_if.sink    req_if,
   mhsi_stream_if.source  rsp_if,
   mhsi_stream_if.sink    csr_if
);

   // configuration registers
   mhsi_cfg_type cfg_ff, cfg_in;

   // front -> queue -> back
   mhsi_stream_if #(.payload_type(mhsi_item_type)) front_if ();
   mhsi_stream_if #(.payload_type(mhsi_item_type)) queue_if ();

   // csr port is always ready, each write is registered into cfg_ff
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.data.index)
            REG_SCALE_GAIN:   cfg_in.scale_gain        = csr_if.data.value[GAIN_W-1:0];
            REG_MATRIX_ROW_X: cfg_in.matrix[0]         = csr_if.data.value;
            REG_MATRIX_ROW_Y: cfg_in.matrix[1]         = csr_if.data.value;
            REG_MATRIX_ROW_Z: cfg_in.matrix[2]         = csr_if.data.value;
            REG_CORR_ENABLE:  cfg_in.correction_enable = csr_if.data.value[0];
            // unmapped index, word dropped
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_gain        <= SCALE_GAIN_RESET;
         cfg_ff.matrix[0]         <= MATRIX_ROW_X_RESET;
         cfg_ff.matrix[1]         <= MATRIX_ROW_Y_RESET;
         cfg_ff.matrix[2]         <= MATRIX_ROW_Z_RESET;
         cfg_ff.correction_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front register classifies each request word
   mhsi_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .item_if (front_if)
   );

   // short fifo so front and back stall independently
   mhsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .in_if  (front_if),
      .out_if (queue_if)
   );

   // sequencer with the shared multiplier and the calibration state
   mhsi_back #(
      .MIN_SAMPLES (MIN_SAMPLES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item_if (queue_if),
      .rsp_if  (rsp_if)
   );

`ifndef SYNTHESIS
   // an error status only comes from finish, which returns zero fields
   a_status_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.status |->
         rsp_if.data.field_x == '0 && rsp_if.data.field_y == '0 &&
         rsp_if.data.field_z == '0)
      else $error("error status with nonzero fields");

   // calibration is never lost outside reset
   a_calib_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.data.is_calibrated |=>
         !rsp_if.valid || rsp_if.data.is_calibrated)
      else $error("calibrated flag dropped");
`endif

endmodule

[sv/mhsi_front.sv]
// front stage: accepts request words and classifies them for the back end
`timescale 1ns / 1ps

module mhsi_front
   import mhsi_pkg::*;
(
   input logic            clock,
   input logic            reset,
   mhsi_stream_if.sink    req_if,
   mhsi_stream_if.source  item_if
);

   logic          valid_ff, valid_in;
   mhsi_item_type item_ff, item_in;
   logic          needs_scale;
   logic          take;

   assign req_if.ready = !valid_ff || item_if.ready;
   assign take         = req_if.valid && req_if.ready;

   // begin and finish produce zero fields, no multiplies needed
   always_comb begin
      unique case (req_if.data.command) inside
         CMD_MEASURE, CMD_SAMPLE: needs_scale = 1'b1;
         CMD_BEGIN, CMD_FINISH:   needs_scale = 1'b0;
         default:                 needs_scale = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_if.ready) begin
         valid_in = req_if.valid;
      end
      if (take) begin
         item_in.cmd         = req_if.data.command;
         item_in.needs_scale = needs_scale;
         item_in.raw[0]      = req_if.data.raw_x;
         item_in.raw[1]      = req_if.data.raw_y;
         item_in.raw[2]      = req_if.data.raw_z;
      end
   end

   assign item_if.valid = valid_ff;
   assign item_if.data  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

[sv/mhsi_queue.sv]
// short fifo decoupling the front stage from the back end
`timescale 1ns / 1ps

module mhsi_queue
   import mhsi_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input logic            clock,
   input logic            reset,
   mhsi_stream_if.sink    in_if,
   mhsi_stream_if.source  out_if
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mhsi_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_if.ready  = (count_ff != FULL_CNT);
   assign out_if.valid = (count_ff != '0);
   assign out_if.data  = entry_ff[rd_ptr_ff];

   assign push = in_if.valid && in_if.ready;
   assign pop  = out_if.valid && out_if.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_if.data;
      end
   end

endmodule

[sv/mhsi_back.sv]
// back end: shared-multiplier sequencer for scaling, correction and calibration
`timescale 1ns / 1ps

module mhsi_back
   import mhsi_pkg::*;
#(
   parameter int unsigned MIN_SAMPLES = MIN_SAMPLES_DEFAULT
)(
   input logic            clock,
   input logic            reset,
   input mhsi_cfg_type    cfg,
   mhsi_stream_if.sink    item_if,
   mhsi_stream_if.source  rsp_if
);

   localparam logic [TALLY_W-1:0] MIN_TALLY = TALLY_W'(MIN_SAMPLES);
   localparam logic [3:0] OP_LAST_SCALE  = 4'd2;
   localparam logic [3:0] OP_LAST_MATRIX = 4'd11;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_MULT   = 3'b010,
      S_FINISH = 3'b100
   } bk_state_type;

   typedef struct packed {
      logic       is_scale;
      logic [1:0] row;
      logic [1:0] col;
   } bk_op_type;

   // ops 0..2 scale an axis, ops 3..11 walk the matrix row by row
   function automatic bk_op_type op_decode(input logic [3:0] op);
      bk_op_type d;
      d = '0;
      case (op)
         4'd0:    d = '{is_scale: 1'b1, row: 2'd0, col: 2'd0};
         4'd1:    d = '{is_scale: 1'b1, row: 2'd0, col: 2'd1};
         4'd2:    d = '{is_scale: 1'b1, row: 2'd0, col: 2'd2};
         4'd3:    d = '{is_scale: 1'b0, row: 2'd0, col: 2'd0};
         4'd4:    d = '{is_scale: 1'b0, row: 2'd0, col: 2'd1};
         4'd5:    d = '{is_scale: 1'b0, row: 2'd0, col: 2'd2};
         4'd6:    d = '{is_scale: 1'b0, row: 2'd1, col: 2'd0};
         4'd7:    d = '{is_scale: 1'b0, row: 2'd1, col: 2'd1};
         4'd8:    d = '{is_scale: 1'b0, row: 2'd1, col: 2'd2};
         4'd9:    d = '{is_scale: 1'b0, row: 2'd2, col: 2'd0};
         4'd10:   d = '{is_scale: 1'b0, row: 2'd2, col: 2'd1};
         4'd11:   d = '{is_scale: 1'b0, row: 2'd2, col: 2'd2};
         default: d = '0;
      endcase
      return d;
   endfunction

   function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [43:0] v);
      logic signed [FIELD_W-1:0] r;
      r = v[FIELD_W-1:0];
      if (v > 44'(FIELD_MAX)) begin
         r = FIELD_MAX;
      end else if (v < 44'(FIELD_MIN)) begin
         r = FIELD_MIN;
      end
      return r;
   endfunction

   bk_state_type state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [3:0]   last_ff, last_in;
   logic         pvld_ff, pvld_in;
   logic [3:0]   pop_ff, pop_in;
   logic         correct_ff, correct_in;
   mhsi_item_type item_ff, item_in;

   logic signed [51:0] prod_ff, prod_in;
   logic signed [53:0] acc_ff, acc_in;

   logic signed [FIELD_W-1:0] unc_ff    [3];
   logic signed [FIELD_W-1:0] unc_in    [3];
   logic signed [FIELD_W:0]   d_ff      [3];
   logic signed [FIELD_W:0]   d_in      [3];
   logic signed [FIELD_W-1:0] res_ff    [3];
   logic signed [FIELD_W-1:0] res_in    [3];
   logic signed [FIELD_W-1:0] min_ff    [3];
   logic signed [FIELD_W-1:0] min_in    [3];
   logic signed [FIELD_W-1:0] max_ff    [3];
   logic signed [FIELD_W-1:0] max_in    [3];
   logic signed [FIELD_W-1:0] offset_ff [3];
   logic signed [FIELD_W-1:0] offset_in [3];
   logic [TALLY_W-1:0]        tally_ff, tally_in;
   logic                      calib_ff, calib_in;

   logic         rsp_valid_ff, rsp_valid_in;
   mhsi_rsp_type rsp_data_ff, rsp_data_in;

   bk_op_type                 iss, cons;
   logic signed [32:0]        mul_a;
   logic signed [18:0]        mul_b;
   logic signed [51:0]        mul_p;
   logic [COEF_W-1:0]         coef;
   logic [RAW_W-1:0]          raw_sel;
   logic signed [FIELD_W-1:0] unc_new;
   logic signed [53:0]        acc_next;
   logic signed [39:0]        acc_shift;
   logic signed [FIELD_W:0]   mid_sum [3];
   logic signed [FIELD_W-1:0] fld     [3];
   logic                      take, emit;

   assign item_if.ready = (state_ff == S_IDLE);
   assign take          = item_if.valid && item_if.ready;
   assign emit          = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // shared multiplier, operands picked by the issuing op
   always_comb begin
      iss     = op_decode(cnt_ff);
      raw_sel = item_ff.raw[iss.col];
      coef    = cfg.matrix[iss.row][{iss.col, 4'b0000} +: COEF_W];
      if (iss.is_scale) begin
         mul_a = {{(33 - RAW_W){raw_sel[RAW_W-1]}}, raw_sel};
         mul_b = {1'b0, cfg.scale_gain};
      end else begin
         mul_a = d_ff[iss.col];
         mul_b = {{(19 - COEF_W){coef[COEF_W-1]}}, coef};
      end
      mul_p = mul_a * mul_b;
   end

   // consume side of the registered product
   always_comb begin
      cons      = op_decode(pop_ff);
      unc_new   = sat32(prod_ff[51:8]);
      acc_next  = (cons.col == 2'd0) ? 54'(prod_ff) : acc_ff + 54'(prod_ff);
      acc_shift = acc_next[53:14];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      pvld_in      = 1'b0;
      pop_in       = pop_ff;
      correct_in   = correct_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      tally_in     = tally_ff;
      calib_in     = calib_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < 3; i++) begin
         unc_in[i]    = unc_ff[i];
         d_in[i]      = d_ff[i];
         res_in[i]    = res_ff[i];
         min_in[i]    = min_ff[i];
         max_in[i]    = max_ff[i];
         offset_in[i] = offset_ff[i];
         mid_sum[i]   = {min_ff[i][FIELD_W-1], min_ff[i]} + {max_ff[i][FIELD_W-1], max_ff[i]};
         fld[i]       = correct_ff ? res_ff[i] : unc_ff[i];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               item_in    = item_if.data;
               correct_in = cfg.correction_enable && calib_ff;
               last_in    = (cfg.correction_enable && calib_ff) ? OP_LAST_MATRIX
                                                                : OP_LAST_SCALE;
               cnt_in     = '0;
               state_in   = item_if.data.needs_scale ? S_MULT : S_FINISH;
            end
         end
         S_MULT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff <= last_ff) begin
               pvld_in = 1'b1;
               pop_in  = cnt_ff;
               prod_in = mul_p;
            end
            if (pvld_ff) begin
               if (cons.is_scale) begin
                  unc_in[cons.col] = unc_new;
                  d_in[cons.col]   = {unc_new[FIELD_W-1], unc_new}
                                   - {offset_ff[cons.col][FIELD_W-1], offset_ff[cons.col]};
               end else begin
                  acc_in = acc_next;
                  if (cons.col == 2'd2) begin
                     res_in[cons.row] = sat32(44'(acc_shift));
                  end
               end
               if (pop_ff == last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (emit) begin
               state_in            = S_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = 1'b0;
               rsp_data_in.field_x = '0;
               rsp_data_in.field_y = '0;
               rsp_data_in.field_z = '0;
               unique case (item_ff.cmd)
                  CMD_MEASURE: begin
                     rsp_data_in.field_x = fld[0];
                     rsp_data_in.field_y = fld[1];
                     rsp_data_in.field_z = fld[2];
                  end
                  CMD_SAMPLE: begin
                     rsp_data_in.field_x = fld[0];
                     rsp_data_in.field_y = fld[1];
                     rsp_data_in.field_z = fld[2];
                     for (int i = 0; i < 3; i++) begin
                        if (unc_ff[i] < min_ff[i]) begin
                           min_in[i] = unc_ff[i];
                        end
                        if (unc_ff[i] > max_ff[i]) begin
                           max_in[i] = unc_ff[i];
                        end
                     end
                     if (tally_ff != '1) begin
                        tally_in = tally_ff + 1'b1;
                     end
                  end
                  CMD_BEGIN: begin
                     for (int i = 0; i < 3; i++) begin
                        min_in[i] = FIELD_MAX;
                        max_in[i] = FIELD_MIN;
                     end
                     tally_in = '0;
                  end
                  CMD_FINISH: begin
                     // floored midpoint of the tracked span
                     if (tally_ff >= MIN_TALLY) begin
                        for (int i = 0; i < 3; i++) begin
                           offset_in[i] = mid_sum[i][FIELD_W:1];
                        end
                        calib_in = 1'b1;
                     end else begin
                        rsp_data_in.status = 1'b1;
                     end
                  end
                  default: begin
                     rsp_data_in.status = 1'b0;
                  end
               endcase
               rsp_data_in.is_calibrated = calib_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pvld_ff      <= 1'b0;
         tally_ff     <= '0;
         calib_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i]    <= FIELD_MAX;
            max_ff[i]    <= FIELD_MIN;
            offset_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pvld_ff      <= pvld_in;
         tally_ff     <= tally_in;
         calib_ff     <= calib_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            min_ff[i]    <= min_in[i];
            max_ff[i]    <= max_in[i];
            offset_ff[i] <= offset_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      pop_ff      <= pop_in;
      correct_ff  <= correct_in;
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         unc_ff[i] <= unc_in[i];
         d_ff[i]   <= d_in[i];
         res_ff[i] <= res_in[i];
      end
   end

endmodule

[test/testbench.sv]
// self-checking testbench of the magnetometer hard/soft-iron correction block
`timescale 1ns / 1ps

module testbench;
   import mhsi_pkg::*;

   // cycles with no word moving on any channel before the run is declared hung
   localparam int unsigned QUIET_LIMIT   = 5000;
   // back end's longest word is a corrected measure or sample, give it some margin
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS   = 250;
   localparam int unsigned PHASE_COUNT   = 8;
   // first index past the register list, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_UNUSED = REG_CORR_ENABLE + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST_UNUSED  = '1;
   localparam logic [GAIN_W-1:0]      GAIN_TOP         = '1;
   localparam logic [RAW_W-1:0]       RAW_TOP          = 24'h7F_FFFF;
   localparam logic [RAW_W-1:0]       RAW_BOTTOM       = 24'h80_0000;

   // field predictor: own copy of the registers and the calibration state,
   // one predicted response word per accepted request word
   class mag_field_ledger;
      logic [GAIN_W-1:0] gain;
      logic [ROW_W-1:0]  rows [3];
      logic              corr_on;
      longint            lo [3];
      longint            hi [3];
      longint            offset [3];
      int unsigned       tally;
      bit                calibrated;
      mhsi_rsp_type      coming_fields [$];
      int unsigned       failures;

      function new();
         gain    = SCALE_GAIN_RESET;
         rows[0] = MATRIX_ROW_X_RESET;
         rows[1] = MATRIX_ROW_Y_RESET;
         rows[2] = MATRIX_ROW_Z_RESET;
         corr_on = 1'b0;
         for (int i = 0; i < 3; i++) begin
            lo[i]     = longint'(FIELD_MAX);
            hi[i]     = longint'(FIELD_MIN);
            offset[i] = 0;
         end
         tally      = 0;
         calibrated = 1'b0;
         failures   = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [ROW_W-1:0] val);
         case (idx)
            REG_SCALE_GAIN:   gain    = val[GAIN_W-1:0];
            REG_MATRIX_ROW_X: rows[0] = val;
            REG_MATRIX_ROW_Y: rows[1] = val;
            REG_MATRIX_ROW_Z: rows[2] = val;
            REG_CORR_ENABLE:  corr_on = val[0];
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > longint'(FIELD_MAX)) return longint'(FIELD_MAX);
         if (v < longint'(FIELD_MIN)) return longint'(FIELD_MIN);
         return v;
      endfunction

      function void note_request(mhsi_req_type w);
         longint                   raw [3];
         longint                   unc [3];
         longint                   fld [3];
         longint                   diff [3];
         longint                   acc;
         logic signed [COEF_W-1:0] c;
         mhsi_rsp_type             want;
         raw[0] = longint'(w.raw_x);
         raw[1] = longint'(w.raw_y);
         raw[2] = longint'(w.raw_z);
         // scaled value, floored to q24.8 and saturated
         for (int i = 0; i < 3; i++) begin
            unc[i] = clamp32((raw[i] * longint'(gain)) >>> 8);
            fld[i] = unc[i];
         end
         if (corr_on && calibrated) begin
            for (int i = 0; i < 3; i++)
               diff[i] = unc[i] - offset[i];
            for (int i = 0; i < 3; i++) begin
               acc = 0;
               for (int j = 0; j < 3; j++) begin
                  c = rows[i][COEF_W*j +: COEF_W];
                  acc += c * diff[j];
               end
               fld[i] = clamp32(acc >>> 14);
            end
         end
         want.status = 1'b0;
         case (w.command)
            CMD_BEGIN: begin
               for (int i = 0; i < 3; i++) begin
                  lo[i]  = longint'(FIELD_MAX);
                  hi[i]  = longint'(FIELD_MIN);
                  fld[i] = 0;
               end
               tally = 0;
            end
            CMD_SAMPLE: begin
               for (int i = 0; i < 3; i++) begin
                  if (unc[i] < lo[i]) lo[i] = unc[i];
                  if (unc[i] > hi[i]) hi[i] = unc[i];
               end
               if (tally < 255) tally++;
            end
            CMD_FINISH: begin
               for (int i = 0; i < 3; i++)
                  fld[i] = 0;
               if (tally >= MIN_SAMPLES_DEFAULT) begin
                  for (int i = 0; i < 3; i++)
                     offset[i] = (lo[i] + hi[i]) >>> 1;
                  calibrated = 1'b1;
               end else begin
                  want.status = 1'b1;
               end
            end
            default: ;
         endcase
         want.field_x       = FIELD_W'(fld[0]);
         want.field_y       = FIELD_W'(fld[1]);
         want.field_z       = FIELD_W'(fld[2]);
         want.is_calibrated = calibrated;
         coming_fields.push_back(want);
      endfunction

      function void compare_field(string label, logic [FIELD_W-1:0] want,
                                  logic [FIELD_W-1:0] seen);
         if (want !== seen) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, $signed(want),
                     $signed(seen));
            failures++;
         end
      endfunction

      function void match_response(mhsi_rsp_type got);
         mhsi_rsp_type want;
         if (coming_fields.size() == 0) begin
            $display("%0t: response word with nothing expected, field_x %0d", $time,
                     got.field_x);
            failures++;
            return;
         end
         want = coming_fields.pop_front();
         compare_field("field_x", want.field_x, got.field_x);
         compare_field("field_y", want.field_y, got.field_y);
         compare_field("field_z", want.field_z, got.field_z);
         compare_field("status", FIELD_W'(want.status), FIELD_W'(got.status));
         compare_field("is_calibrated", FIELD_W'(want.is_calibrated),
                       FIELD_W'(got.is_calibrated));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mhsi_stream_if #(.payload_type(mhsi_req_type)) req_if ();
   mhsi_stream_if #(.payload_type(mhsi_rsp_type)) rsp_if ();
   mhsi_stream_if #(.payload_type(mhsi_csr_type)) csr_if ();

   mag_field_ledger ledger = new();

   // idle odds in percent, changed between phases
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   int unsigned quiet_cycles   = 0;

   magnetometer_hard_soft_iron_correct i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: ready redrawn at every falling edge
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: every word that moves at a rising edge goes to the ledger,
   // the request before the response so a same-edge pass-through still lines up
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            ledger.write_register(csr_if.data.index, csr_if.data.value);
         if (req_if.valid && req_if.ready)
            ledger.note_request(req_if.data);
         if (rsp_if.valid && rsp_if.ready)
            ledger.match_response(rsp_if.data);
      end
   end

   // watchdog on cycles where no word moves anywhere
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one request word; the idle gap sits in front so valid is never
   // dropped and raised in the same step
   task automatic send_request(input mhsi_cmd_type cmd, input logic [RAW_W-1:0] x,
                               input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z);
      mhsi_req_type w;
      w.command = cmd;
      w.raw_x   = x;
      w.raw_y   = y;
      w.raw_z   = z;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do begin
         @(posedge clock);
      end while (req_if.ready !== 1'b1);
      items_sent++;
      @(negedge clock);
   endtask

   // one register write word, caller lowers valid after the last one
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [ROW_W-1:0] val);
      mhsi_csr_type w;
      w.index = idx;
      w.value = val;
      csr_if.valid <= 1'b1;
      csr_if.data  <= w;
      do begin
         @(posedge clock);
      end while (csr_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // hold off until every predicted word has come back, then let the back end settle
   task automatic wait_for_drain();
      while (ledger.coming_fields.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // axis count: extremes, small values around zero, or any bit pattern
   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(9))
         0: return RAW_TOP;
         1: return RAW_BOTTOM;
         2, 3: return RAW_W'($urandom_range(2000)) - RAW_W'(1000);
         default: return RAW_W'($urandom());
      endcase
   endfunction

   // mostly calibration runs with random content, some plain measures,
   // a little noise of random commands
   task automatic play_random_burst();
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         // now and then samples pile onto the old min/max with no begin
         if ($urandom_range(9) > 2)
            send_request(CMD_BEGIN, pick_raw(), pick_raw(), pick_raw());
         // short runs hit the too-few-samples error, rare long ones the tally ceiling
         n = ($urandom_range(99) < 2) ? $urandom_range(250, 300) : $urandom_range(1, 14);
         repeat (n) send_request(CMD_SAMPLE, pick_raw(), pick_raw(), pick_raw());
         send_request(CMD_FINISH, pick_raw(), pick_raw(), pick_raw());
         repeat ($urandom_range(1, 6))
            send_request(CMD_MEASURE, pick_raw(), pick_raw(), pick_raw());
      end else if (kind <= 8) begin
         repeat ($urandom_range(1, 8))
            send_request(CMD_MEASURE, pick_raw(), pick_raw(), pick_raw());
      end else begin
         repeat ($urandom_range(1, 5))
            send_request(mhsi_cmd_type'($urandom_range(3)), pick_raw(), pick_raw(),
                         pick_raw());
      end
   endtask

   initial begin
      int unsigned       phase_start;
      logic [GAIN_W-1:0] gain;
      logic [ROW_W-1:0]  row [3];
      logic              enable;

      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at reset settings: sample before any begin tracks from
      // the reset min/max, then extremes, a finish with too few samples and
      // a good finish
      send_request(CMD_SAMPLE, RAW_TOP, RAW_BOTTOM, '0);
      send_request(CMD_MEASURE, RAW_TOP, RAW_TOP, RAW_TOP);
      send_request(CMD_MEASURE, RAW_BOTTOM, RAW_BOTTOM, RAW_BOTTOM);
      send_request(CMD_MEASURE, '0, '1, RAW_W'(1));
      send_request(CMD_BEGIN, RAW_TOP, RAW_BOTTOM, RAW_TOP);
      repeat (5) send_request(CMD_SAMPLE, pick_raw(), pick_raw(), pick_raw());
      send_request(CMD_FINISH, RAW_TOP, RAW_TOP, RAW_TOP);
      send_request(CMD_SAMPLE, RAW_BOTTOM, RAW_TOP, '1);
      send_request(CMD_FINISH, '0, '0, '0);
      send_request(CMD_MEASURE, RAW_TOP, RAW_BOTTOM, RAW_W'(1));
      // finish again keeps the old min/max and tally
      send_request(CMD_FINISH, '1, '1, '1);
      req_if.valid <= 1'b0;
      wait_for_drain();

      // largest gain saturates the scaled value, correction on with identity
      write_csr(REG_SCALE_GAIN, ROW_W'(GAIN_TOP));
      write_csr(REG_CORR_ENABLE, ROW_W'(1'b1));
      csr_if.valid <= 1'b0;
      send_request(CMD_MEASURE, RAW_TOP, RAW_TOP, RAW_TOP);
      send_request(CMD_MEASURE, RAW_BOTTOM, RAW_BOTTOM, RAW_BOTTOM);
      // begin and finish with no samples: error, offsets and flag stay
      send_request(CMD_BEGIN, pick_raw(), pick_raw(), pick_raw());
      send_request(CMD_FINISH, pick_raw(), pick_raw(), pick_raw());
      send_request(CMD_MEASURE, pick_raw(), pick_raw(), pick_raw());
      send_request(CMD_SAMPLE, pick_raw(), pick_raw(), pick_raw());
      req_if.valid <= 1'b0;
      wait_for_drain();

      // random phases, each with its own register set and idle pattern;
      // the sender holds off for a full drain between phases
      for (int p = 0; p < PHASE_COUNT; p++) begin
         gain   = GAIN_W'($urandom_range(GAIN_TOP));
         row[0] = ROW_W'({$urandom(), $urandom()});
         row[1] = ROW_W'({$urandom(), $urandom()});
         row[2] = ROW_W'({$urandom(), $urandom()});
         enable = 1'b1;
         case (p)
            0: begin
               // top gain, identity matrix
               gain   = GAIN_TOP;
               row[0] = MATRIX_ROW_X_RESET;
               row[1] = MATRIX_ROW_Y_RESET;
               row[2] = MATRIX_ROW_Z_RESET;
            end
            1: gain = '0;
            2: begin
               // every coefficient at its positive extreme
               row[0] = {3{16'h7FFF}};
               row[1] = {3{16'h7FFF}};
               row[2] = {3{16'h7FFF}};
            end
            3: begin
               // every coefficient at its negative extreme
               row[0] = {3{16'h8000}};
               row[1] = {3{16'h8000}};
               row[2] = {3{16'h8000}};
            end
            4: enable = 1'b0;
            default: enable = 1'($urandom_range(1));
         endcase
         write_csr(REG_SCALE_GAIN, ROW_W'(gain));
         write_csr(REG_MATRIX_ROW_X, row[0]);
         write_csr(REG_MATRIX_ROW_Y, row[1]);
         write_csr(REG_MATRIX_ROW_Z, row[2]);
         write_csr(REG_CORR_ENABLE, ROW_W'(enable));
         // past the register list, must change nothing
         write_csr(CSR_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                   ROW_W'({$urandom(), $urandom()}));
         csr_if.valid <= 1'b0;

         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 80;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 80;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            play_random_burst();
         req_if.valid <= 1'b0;
         wait_for_drain();
      end

      if (ledger.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
